// ----- rtl/ehnm_pkg.sv -----
// Shared types and constants of the edge hash neighbour matcher.
// Depends on nothing; every other file but ehnm_ram refers to it by scoped names.
package ehnm_pkg;

  localparam int VertW     = 13;
  localparam int TriW      = 14;
  localparam int SlotW     = 2;
  localparam int CntW      = 15;
  localparam int MaxEntries = 16384;
  localparam int MaxVertices = 4096;
  localparam int HeadSize  = 2 * MaxVertices + 1;
  localparam int KeyW      = $clog2(HeadSize);
  localparam int EntAddrW  = $clog2(MaxEntries);
  localparam int EntDataW  = 2 * VertW + TriW + SlotW;
  localparam int QueueDepth = 2;

  localparam logic [CntW-1:0] LimitReset = CntW'(MaxEntries);

  typedef struct packed {
    logic [VertW-1:0] v1;
    logic [VertW-1:0] v2;
    logic [TriW-1:0]  owner;
    logic [SlotW-1:0] slot;
    logic [KeyW-1:0]  key;
  } item_t;

  typedef struct packed {
    logic init_done;
  } back_status_t;

endpackage

// ----- rtl/ehnm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module ehnm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/ehnm_front.sv -----
// Front stage: take input transactions, compute the bucket key, hand on.
// Depends on ehnm_pkg.
module ehnm_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ehnm_pkg::VertW-1:0]     first_vertex_i,
  input  logic [ehnm_pkg::VertW-1:0]     second_vertex_i,
  input  logic [ehnm_pkg::TriW-1:0]      triangle_i,
  input  logic [ehnm_pkg::SlotW-1:0]     edge_slot_i,
  input  ehnm_pkg::back_status_t         status_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output ehnm_pkg::item_t                push_item_o
);

  logic            valid_q;
  ehnm_pkg::item_t item_q;
  logic [ehnm_pkg::KeyW:0] sum;
  logic [ehnm_pkg::KeyW-1:0] key;

  // vertex sum modulo the head size: sum stays below twice the head size
  assign sum = (ehnm_pkg::KeyW+1)'(first_vertex_i) + (ehnm_pkg::KeyW+1)'(second_vertex_i);
  assign key = (sum >= (ehnm_pkg::KeyW+1)'(ehnm_pkg::HeadSize))
             ? ehnm_pkg::KeyW'(sum - (ehnm_pkg::KeyW+1)'(ehnm_pkg::HeadSize))
             : ehnm_pkg::KeyW'(sum);

  assign in_ready_o   = status_i.init_done && (!valid_q || push_ready_i);
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (push_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.v1    <= first_vertex_i;
      item_q.v2    <= second_vertex_i;
      item_q.owner <= triangle_i;
      item_q.slot  <= edge_slot_i;
      item_q.key   <= key;
    end
  end

endmodule

// ----- rtl/ehnm_queue.sv -----
// Short queue between the front and the back stage.
// Depends on ehnm_pkg.
module ehnm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ehnm_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_i,
  output ehnm_pkg::item_t pop_item_o
);

  localparam int PtrW = $clog2(ehnm_pkg::QueueDepth);

  ehnm_pkg::item_t       slots_q [ehnm_pkg::QueueDepth];
  logic [PtrW-1:0]       wptr_q, rptr_q;
  logic [PtrW:0]         cnt_q;
  logic                  push, pop;

  assign push_ready_o = (cnt_q != (PtrW+1)'(ehnm_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = slots_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PtrW'(ehnm_pkg::QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == PtrW'(ehnm_pkg::QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wptr_q] <= push_item_i;
    end
  end

endmodule

// ----- rtl/ehnm_back.sv -----
// Back stage: head table clear, chain walk, entry append and result register.
// Depends on ehnm_pkg and ehnm_ram.
module ehnm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ehnm_pkg::CntW-1:0]     limit_i,
  input  logic                          pop_valid_i,
  output logic                          pop_o,
  input  ehnm_pkg::item_t               pop_item_i,
  output ehnm_pkg::back_status_t        status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ehnm_pkg::TriW-1:0]     own_triangle_o,
  output logic [ehnm_pkg::SlotW-1:0]    own_edge_o,
  output logic                          matched_o,
  output logic [ehnm_pkg::TriW-1:0]     neighbor_triangle_o,
  output logic [ehnm_pkg::SlotW-1:0]    neighbor_edge_o,
  output logic                          table_full_o
);

  localparam int CntW = ehnm_pkg::CntW;
  localparam int KeyW = ehnm_pkg::KeyW;
  localparam int EAW  = ehnm_pkg::EntAddrW;
  localparam int EDW  = ehnm_pkg::EntDataW;
  localparam int VW   = ehnm_pkg::VertW;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_HEAD, S_CMP, S_MISS, S_LINK
  } state_e;

  state_e            state_q;
  ehnm_pkg::item_t   job_q;
  logic [CntW-1:0]   cur_q, last_q, cnt_q;
  logic [KeyW-1:0]   clr_q;

  logic              head_we;
  logic [KeyW-1:0]   head_waddr, head_raddr;
  logic [CntW-1:0]   head_wdata, head_rdata;
  logic              data_we;
  logic [EDW-1:0]    data_wdata, data_rdata;
  logic              next_we;
  logic [EAW-1:0]    next_waddr, ent_raddr;
  logic [CntW-1:0]   next_wdata, next_rdata, rd_sel;
  logic [CntW-1:0]   lim;
  logic              pair_hit;
  logic [VW-1:0]     ev1, ev2;

  assign lim = (limit_i > CntW'(ehnm_pkg::MaxEntries)) ? CntW'(ehnm_pkg::MaxEntries) : limit_i;
  assign status_o.init_done = (state_q != S_INIT);
  assign pop_o = (state_q == S_IDLE) && pop_valid_i && !out_valid_o;

  assign head_raddr = pop_item_i.key;
  assign head_we    = (state_q == S_INIT) || ((state_q == S_LINK) && (last_q == '0));
  assign head_waddr = (state_q == S_INIT) ? clr_q : job_q.key;
  assign head_wdata = (state_q == S_INIT) ? '0 : cnt_q;

  // entry n lives at address n-1
  assign rd_sel    = (state_q == S_HEAD) ? head_rdata : next_rdata;
  assign ent_raddr = EAW'(rd_sel - 1'b1);

  assign data_we    = (state_q == S_MISS) && (cnt_q < lim);
  assign data_wdata = {job_q.v1, job_q.v2, job_q.owner, job_q.slot};
  assign next_we    = data_we || ((state_q == S_LINK) && (last_q != '0));
  assign next_waddr = (state_q == S_MISS) ? EAW'(cnt_q) : EAW'(last_q - 1'b1);
  assign next_wdata = (state_q == S_MISS) ? '0 : cnt_q;

  assign ev1 = data_rdata[EDW-1 -: VW];
  assign ev2 = data_rdata[EDW-VW-1 -: VW];
  assign pair_hit = (ev1 == job_q.v1 && ev2 == job_q.v2) ||
                    (ev1 == job_q.v2 && ev2 == job_q.v1);

  ehnm_ram #(.Width(CntW), .Depth(ehnm_pkg::HeadSize)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );

  ehnm_ram #(.Width(EDW), .Depth(ehnm_pkg::MaxEntries)) u_data (
    .clk_i, .we_i(data_we), .waddr_i(EAW'(cnt_q)), .wdata_i(data_wdata),
    .raddr_i(ent_raddr), .rdata_o(data_rdata)
  );

  ehnm_ram #(.Width(CntW), .Depth(ehnm_pkg::MaxEntries)) u_next (
    .clk_i, .we_i(next_we), .waddr_i(next_waddr), .wdata_i(next_wdata),
    .raddr_i(ent_raddr), .rdata_o(next_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == KeyW'(ehnm_pkg::HeadSize - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop_o) begin
            job_q   <= pop_item_i;
            last_q  <= '0;
            state_q <= S_HEAD;
          end
        end
        S_HEAD: begin
          cur_q   <= head_rdata;
          state_q <= (head_rdata == '0) ? S_MISS : S_CMP;
        end
        S_CMP: begin
          if (pair_hit) begin
            out_valid_o         <= 1'b1;
            own_triangle_o      <= job_q.owner;
            own_edge_o          <= job_q.slot;
            matched_o           <= 1'b1;
            neighbor_triangle_o <= data_rdata[ehnm_pkg::SlotW +: ehnm_pkg::TriW];
            neighbor_edge_o     <= data_rdata[ehnm_pkg::SlotW-1:0];
            table_full_o        <= (cnt_q >= lim);
            state_q             <= S_IDLE;
          end else begin
            last_q  <= cur_q;
            cur_q   <= next_rdata;
            state_q <= (next_rdata == '0) ? S_MISS : S_CMP;
          end
        end
        S_MISS: begin
          if (cnt_q < lim) begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_LINK;
          end else begin
            // drop the edge, report full
            out_valid_o         <= 1'b1;
            own_triangle_o      <= job_q.owner;
            own_edge_o          <= job_q.slot;
            matched_o           <= 1'b0;
            neighbor_triangle_o <= '0;
            neighbor_edge_o     <= '0;
            table_full_o        <= 1'b1;
            state_q             <= S_IDLE;
          end
        end
        S_LINK: begin
          out_valid_o         <= 1'b1;
          own_triangle_o      <= job_q.owner;
          own_edge_o          <= job_q.slot;
          matched_o           <= 1'b0;
          neighbor_triangle_o <= '0;
          neighbor_edge_o     <= '0;
          table_full_o        <= (cnt_q >= lim);
          state_q             <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ehnm_pkg::MaxEntries)) else $error("entry count beyond capacity");
  a_no_out_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INIT |-> !out_valid_o) else $error("result during head clear");
  a_walk_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> cur_q != '0) else $error("chain walk on empty link");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !matched_o |-> neighbor_triangle_o == '0 && neighbor_edge_o == '0)
    else $error("neighbour reported on miss");
`endif

endmodule

// ----- rtl/edge_hash_neighbor_matcher_unit.sv -----
// Path: a hit goes through the front register, the queue, the head read in S_HEAD and
// one S_CMP compare per chain entry up to the match; a miss walks the whole chain,
// then S_MISS appends and S_LINK links it, or S_MISS drops it when the table is full.
// Flow: one edge at a time in the back stage; a new edge is popped only in S_IDLE once
// the previous result has been taken. The head and entry memories have registered reads.
// Reset: asynchronous, active low; afterwards the head table is cleared entry by entry,
// and no input transaction is accepted until the clear is done.
module edge_hash_neighbor_matcher_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ehnm_pkg::CntW-1:0]   entry_limit_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ehnm_pkg::VertW-1:0]  first_vertex_i,
  input  logic [ehnm_pkg::VertW-1:0]  second_vertex_i,
  input  logic [ehnm_pkg::TriW-1:0]   triangle_i,
  input  logic [ehnm_pkg::SlotW-1:0]  edge_slot_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ehnm_pkg::TriW-1:0]   own_triangle_o,
  output logic [ehnm_pkg::SlotW-1:0]  own_edge_o,
  output logic                        matched_o,
  output logic [ehnm_pkg::TriW-1:0]   neighbor_triangle_o,
  output logic [ehnm_pkg::SlotW-1:0]  neighbor_edge_o,
  output logic                        table_full_o
);

  logic [ehnm_pkg::CntW-1:0] limit_q;
  ehnm_pkg::back_status_t    status;
  ehnm_pkg::item_t           push_item, pop_item;
  logic                      push_valid, push_ready, pop_valid, pop;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= ehnm_pkg::LimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= entry_limit_i;
    end
  end

  // front: accept and hash
  ehnm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .first_vertex_i, .second_vertex_i, .triangle_i, .edge_slot_i,
    .status_i(status), .push_valid_o(push_valid), .push_ready_i(push_ready),
    .push_item_o(push_item)
  );

  // decoupling queue
  ehnm_queue u_queue (
    .clk_i, .rst_ni, .push_valid_i(push_valid), .push_ready_o(push_ready),
    .push_item_i(push_item), .pop_valid_o(pop_valid), .pop_i(pop),
    .pop_item_o(pop_item)
  );

  // back: chain walk and table update
  ehnm_back u_back (
    .clk_i, .rst_ni, .limit_i(limit_q),
    .pop_valid_i(pop_valid), .pop_o(pop), .pop_item_i(pop_item),
    .status_o(status), .out_valid_o, .out_ready_i,
    .own_triangle_o, .own_edge_o, .matched_o,
    .neighbor_triangle_o, .neighbor_edge_o, .table_full_o
  );

endmodule

// ----- test/ehnm_checker.sv -----
// Checker for the edge hash neighbour matcher: watches the config, edge and result
// channels, keeps its own copy of the hash table and compares every result.
// Depends on ehnm_pkg for the field widths.
module ehnm_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [ehnm_pkg::CntW-1:0]   entry_limit_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [ehnm_pkg::VertW-1:0]  first_vertex_i,
  input  logic [ehnm_pkg::VertW-1:0]  second_vertex_i,
  input  logic [ehnm_pkg::TriW-1:0]   triangle_i,
  input  logic [ehnm_pkg::SlotW-1:0]  edge_slot_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [ehnm_pkg::TriW-1:0]   own_triangle_i,
  input  logic [ehnm_pkg::SlotW-1:0]  own_edge_i,
  input  logic                        matched_i,
  input  logic [ehnm_pkg::TriW-1:0]   neighbor_triangle_i,
  input  logic [ehnm_pkg::SlotW-1:0]  neighbor_edge_i,
  input  logic                        table_full_i,
  output int                          pending_o,
  output int                          errors_o,
  output int                          results_o,
  output int                          hits_o,
  output int                          fulls_o
);

  localparam int VertW      = ehnm_pkg::VertW;
  localparam int TriW       = ehnm_pkg::TriW;
  localparam int SlotW      = ehnm_pkg::SlotW;
  localparam int HeadSize   = ehnm_pkg::HeadSize;
  localparam int MaxEntries = ehnm_pkg::MaxEntries;

  typedef struct packed {
    logic [TriW-1:0]  own_tri;
    logic [SlotW-1:0] own_slot;
    logic             hit;
    logic [TriW-1:0]  nb_tri;
    logic [SlotW-1:0] nb_slot;
    logic             full;
  } match_t;

  match_t            match_q[$];
  int unsigned       head_tab[HeadSize];
  logic [VertW-1:0]  ent_va[1:MaxEntries];
  logic [VertW-1:0]  ent_vb[1:MaxEntries];
  logic [TriW-1:0]   ent_owner[1:MaxEntries];
  logic [SlotW-1:0]  ent_slot[1:MaxEntries];
  int unsigned       ent_next[1:MaxEntries];
  int unsigned       ent_count;
  int unsigned       limit_reg;

  assign pending_o = match_q.size();

  // Look the edge up in the table, update it, and return the result.
  function automatic match_t lookup_edge(logic [VertW-1:0] va, logic [VertW-1:0] vb,
                                         logic [TriW-1:0] owner, logic [SlotW-1:0] slot);
    match_t      r;
    int unsigned key, cur, tail, hit_at, lim;
    key    = (int'(va) + int'(vb)) % HeadSize;
    lim    = (limit_reg > MaxEntries) ? MaxEntries : limit_reg;
    cur    = head_tab[key];
    tail   = 0;
    hit_at = 0;
    while (cur != 0) begin
      if ((ent_va[cur] == va && ent_vb[cur] == vb) ||
          (ent_va[cur] == vb && ent_vb[cur] == va)) begin
        hit_at = cur;
        break;
      end
      tail = cur;
      cur  = ent_next[cur];
    end
    r = '0;
    r.own_tri  = owner;
    r.own_slot = slot;
    if (hit_at != 0) begin
      r.hit     = 1'b1;
      r.nb_tri  = ent_owner[hit_at];
      r.nb_slot = ent_slot[hit_at];
    end else if (ent_count < lim) begin
      // append a fresh entry at the tail of the chain
      ent_count++;
      ent_va[ent_count]    = va;
      ent_vb[ent_count]    = vb;
      ent_owner[ent_count] = owner;
      ent_slot[ent_count]  = slot;
      ent_next[ent_count]  = 0;
      if (tail == 0) head_tab[key] = ent_count;
      else ent_next[tail] = ent_count;
    end
    r.full = (ent_count >= lim);
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i) begin
    match_t m;
    if (!rst_ni) begin
      foreach (head_tab[i]) head_tab[i] = 0;
      ent_count = 0;
      limit_reg = MaxEntries;
      errors_o  = 0;
      results_o = 0;
      hits_o    = 0;
      fulls_o   = 0;
    end else begin
      // check the result first: a result never belongs to an edge taken this edge
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (match_q.size() == 0) begin
          report("result with nothing outstanding", 1, 0);
        end else begin
          m = match_q.pop_front();
          if (own_triangle_i != m.own_tri) report("own_triangle", own_triangle_i, m.own_tri);
          if (own_edge_i != m.own_slot) report("own_edge", own_edge_i, m.own_slot);
          if (matched_i !== m.hit) report("matched", matched_i, m.hit);
          if (neighbor_triangle_i != m.nb_tri)
            report("neighbor_triangle", neighbor_triangle_i, m.nb_tri);
          if (neighbor_edge_i != m.nb_slot) report("neighbor_edge", neighbor_edge_i, m.nb_slot);
          if (table_full_i !== m.full) report("table_full", table_full_i, m.full);
          if (m.hit) hits_o++;
          if (m.full) fulls_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) limit_reg = entry_limit_i;
      if (in_valid_i && in_ready_i)
        match_q.push_back(lookup_edge(first_vertex_i, second_vertex_i, triangle_i, edge_slot_i));
    end
  end

endmodule

// ----- test/testbench.sv -----
// Top of the matcher testbench: clock, reset, edge stimulus, config writes and verdict.
// Depends on ehnm_pkg, the matcher unit and the ehnm_checker module.
module testbench;

  localparam int CntW  = ehnm_pkg::CntW;
  localparam int VertW = ehnm_pkg::VertW;
  localparam int TriW  = ehnm_pkg::TriW;
  localparam int SlotW = ehnm_pkg::SlotW;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i, cfg_ready_o;
  logic [CntW-1:0]   entry_limit_i;
  logic              in_valid_i, in_ready_o;
  logic [VertW-1:0]  first_vertex_i, second_vertex_i;
  logic [TriW-1:0]   triangle_i;
  logic [SlotW-1:0]  edge_slot_i;
  logic              out_valid_o, out_ready_i;
  logic [TriW-1:0]   own_triangle_o, neighbor_triangle_o;
  logic [SlotW-1:0]  own_edge_o, neighbor_edge_o;
  logic              matched_o, table_full_o;

  int pending, errors, results, hits, fulls;

  // idling control: quiet stops stalls and gaps for the closing stretch
  bit quiet = 1'b0;
  int stall_left = 0;

  // recently used vertex pairs, replayed to provoke hits
  logic [VertW-1:0] seen_a[64];
  logic [VertW-1:0] seen_b[64];
  int seen_n = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  edge_hash_neighbor_matcher_unit u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .entry_limit_i,
    .in_valid_i, .in_ready_o, .first_vertex_i, .second_vertex_i, .triangle_i, .edge_slot_i,
    .out_valid_o, .out_ready_i, .own_triangle_o, .own_edge_o, .matched_o,
    .neighbor_triangle_o, .neighbor_edge_o, .table_full_o
  );

  ehnm_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .entry_limit_i,
    .in_valid_i, .in_ready_i(in_ready_o), .first_vertex_i, .second_vertex_i,
    .triangle_i, .edge_slot_i,
    .out_valid_i(out_valid_o), .out_ready_i, .own_triangle_i(own_triangle_o),
    .own_edge_i(own_edge_o), .matched_i(matched_o),
    .neighbor_triangle_i(neighbor_triangle_o), .neighbor_edge_i(neighbor_edge_o),
    .table_full_i(table_full_o),
    .pending_o(pending), .errors_o(errors), .results_o(results), .hits_o(hits),
    .fulls_o(fulls)
  );

  // Result side: hold ready low for random bursts, never during the quiet stretch.
  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left  <= $urandom_range(0, 16);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Present one edge and hold it until taken. Ready is sampled mid-cycle, where it
  // is settled and equals its value at the next rising edge.
  task automatic send_edge(logic [VertW-1:0] va, logic [VertW-1:0] vb,
                           logic [TriW-1:0] owner, logic [SlotW-1:0] slot);
    in_valid_i      <= 1'b1;
    first_vertex_i  <= va;
    second_vertex_i <= vb;
    triangle_i      <= owner;
    edge_slot_i     <= slot;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    seen_a[seen_n % 64] = va;
    seen_b[seen_n % 64] = vb;
    seen_n++;
    // drop valid for a random gap now and then
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic write_limit(logic [CntW-1:0] lim);
    cfg_valid_i   <= 1'b1;
    entry_limit_i <= lim;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold stimulus until every outstanding result is back, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
  endtask

  // Mostly pairs from a few crowded buckets or replays of earlier pairs; the rest
  // fully random so every input bit toggles.
  task automatic random_edge();
    logic [VertW-1:0] va, vb;
    int s, k, pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      case ($urandom_range(0, 3))
        0: s = 12;
        1: s = 300;
        2: s = 8193 + 12;
        default: s = 16000;
      endcase
      va = VertW'($urandom_range(s > 8191 ? s - 8191 : 0, s > 8191 ? 8191 : s));
      vb = VertW'(s - int'(va));
    end else if (pick < 8 && seen_n > 0) begin
      k = $urandom_range(0, (seen_n < 64 ? seen_n : 64) - 1);
      if ($urandom_range(0, 1)) begin
        va = seen_a[k];
        vb = seen_b[k];
      end else begin
        va = seen_b[k];
        vb = seen_a[k];
      end
    end else begin
      va = VertW'($urandom);
      vb = VertW'($urandom);
    end
    send_edge(va, vb, TriW'($urandom), SlotW'($urandom));
  endtask

  initial begin
    logic [CntW-1:0] limits[5];
    limits = '{CntW'(20), CntW'(0), CntW'(32767), CntW'(1), CntW'(16384)};
    cfg_valid_i     <= 1'b0;
    entry_limit_i   <= '0;
    in_valid_i      <= 1'b0;
    first_vertex_i  <= '0;
    second_vertex_i <= '0;
    triangle_i      <= '0;
    edge_slot_i     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed edges under the reset limit.
    send_edge(1, 2, 1, 0);          // miss, stored
    send_edge(2, 1, 2, 1);          // swapped pair hits triangle 1
    send_edge(2, 1, 3, 2);          // repeated hit still names the first owner
    send_edge(8191, 8191, 16383, 3); // widest values, slot three
    send_edge(0, 0, 0, 3);
    send_edge(8191, 8191, 5, 1);    // hit reports slot three
    send_edge(3, 9, 10, 0);         // three pairs sharing one bucket
    send_edge(4, 8, 11, 1);
    send_edge(5, 7, 12, 2);
    send_edge(9, 3, 13, 0);         // hit at the chain head
    send_edge(7, 5, 14, 1);         // hit at the chain tail
    send_edge(6, 6, 15, 2);         // miss after a full walk
    send_edge(4096, 4097, 16, 0);   // sum wraps onto the bucket of (0,0)
    send_edge(8192, 1, 17, 1);
    send_edge(4097, 4096, 18, 2);
    send_edge(1, 8192, 19, 0);
    send_edge(0, 0, 8192, 2);
    drain();

    // Random phases, one per limit setting; the last runs without idling.
    for (int p = 0; p < 5; p++) begin
      write_limit(limits[p]);
      if (p == 4) quiet = 1'b1;
      repeat (256) random_edge();
      drain();
    end

    $display("Covered %0d results: %0d neighbour hits, %0d with the table full,", results,
             hits, fulls);
    $display("over entry limits 16384, 20, 0, 32767, 1 and 16384 again.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("Timed out waiting for results");
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ehnm_pkg.sv
rtl/ehnm_ram.sv
rtl/ehnm_front.sv
rtl/ehnm_queue.sv
rtl/ehnm_back.sv
rtl/edge_hash_neighbor_matcher_unit.sv
test/ehnm_checker.sv
test/testbench.sv
